/* rtl/sdpg_pkg.sv */
package sdpg_pkg;

  // Field widths
  localparam int CMD_W     = 2;
  localparam int COUNT_W   = 32;
  localparam int POS_OUT_W = 32;
  localparam int HALF_W    = 16;
  localparam int STEPS_W   = 31;

  // Position counter width default
  localparam int POSITION_BITS_DEF = 32;

  // Register bus
  localparam int DATA_W  = 32;
  localparam int ADDR_W  = 3;
  localparam int INDEX_W = ADDR_W - 2;

  // Command codes; anything else counts as a tick
  localparam logic [CMD_W-1:0] CMD_COUNT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LIMIT = 2'd2;

  // Register indexes
  localparam logic [INDEX_W-1:0] REG_HALF_PERIOD = 1'b0;
  localparam logic [INDEX_W-1:0] REG_FWD_POL     = 1'b1;

  // Reset values of the registers
  localparam logic [HALF_W-1:0] HALF_PERIOD_RST = 16'd1;
  localparam logic              FWD_POL_RST     = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]          command;
    logic signed [COUNT_W-1:0] step_count;
    logic                      limit_hit;
  } item_t;

  typedef struct packed {
    logic                        step_level;
    logic                        dir_level;
    logic                        busy_res;
    logic                        move_done;
    logic signed [POS_OUT_W-1:0] position;
  } result_t;

  typedef struct packed {
    logic [HALF_W-1:0] half_period_ticks;
    logic              forward_polarity;
  } cfg_t;

endpackage

/* rtl/sdpg_ifs.sv */
// Command channel
interface sdpg_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [31:0] step_count;
  logic              limit_hit;

  modport source (output valid, command, step_count, limit_hit, input ready);
  modport sink   (input valid, command, step_count, limit_hit, output ready);
endinterface

// Result channel
interface sdpg_res_if;
  logic               valid;
  logic               ready;
  logic               step_level;
  logic               dir_level;
  logic               busy_res;
  logic               move_done;
  logic signed [31:0] position;

  modport source (output valid, step_level, dir_level, busy_res, move_done, position,
                  input ready);
  modport sink   (input valid, step_level, dir_level, busy_res, move_done, position,
                  output ready);
endinterface

/* rtl/sdpg_cfg_regs.sv */
module sdpg_cfg_regs (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdpg_pkg::ADDR_W-1:0]    paddr,
  input  logic [sdpg_pkg::DATA_W-1:0]    pwdata,
  output logic [sdpg_pkg::DATA_W-1:0]    prdata,
  output logic                           pready,
  output sdpg_pkg::cfg_t                 cfg
);
  import sdpg_pkg::*;

  logic               wr_en;
  logic [INDEX_W-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_W-1:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.half_period_ticks <= HALF_PERIOD_RST;
      cfg.forward_polarity  <= FWD_POL_RST;
    end else if (wr_en) begin
      case (reg_idx)
        REG_HALF_PERIOD: cfg.half_period_ticks <= pwdata[HALF_W-1:0];
        REG_FWD_POL:     cfg.forward_polarity  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    case (reg_idx)
      REG_HALF_PERIOD: prdata = DATA_W'(cfg.half_period_ticks);
      REG_FWD_POL:     prdata = DATA_W'(cfg.forward_polarity);
      default:         prdata = '0;
    endcase
  end

endmodule

/* rtl/sdpg_step_core.sv */
module sdpg_step_core #(
  parameter int POSITION_BITS = sdpg_pkg::POSITION_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  sdpg_pkg::item_t   item,
  input  sdpg_pkg::cfg_t    cfg,
  output sdpg_pkg::result_t res
);
  import sdpg_pkg::*;

  // Motion state
  logic [POSITION_BITS-1:0] position_count, position_count_next;
  logic [STEPS_W-1:0]       steps_left, steps_left_next;
  logic [HALF_W-1:0]        interval_timer, interval_timer_next;
  logic                     pulse_phase_high, pulse_phase_high_next;
  logic                     moving, moving_next;
  logic                     limit_mode, limit_mode_next;
  logic                     going_forward, going_forward_next;
  logic                     dir_pin_level, dir_pin_level_next;

  logic                     done;
  logic [HALF_W-1:0]        load_val;
  logic                     neg;
  logic                     fwd;
  logic [COUNT_W-1:0]       raw;
  logic [COUNT_W-1:0]       mag;
  logic [STEPS_W-1:0]       mag_sat;
  logic [HALF_W-1:0]        timer_dec;
  logic [STEPS_W-1:0]       steps_dec;
  logic                     is_move;

  // Timer load: zero interval acts as one
  assign load_val = (cfg.half_period_ticks == '0) ? HALF_W'(1) : cfg.half_period_ticks;

  // Move decode: direction and saturated magnitude
  assign raw     = item.step_count;
  assign neg     = raw[COUNT_W-1];
  assign fwd     = !neg && (raw != '0);
  assign mag     = neg ? (COUNT_W'(0) - raw) : raw;
  assign mag_sat = mag[COUNT_W-1] ? {STEPS_W{1'b1}} : mag[STEPS_W-1:0];
  assign is_move = (item.command == CMD_COUNT) || (item.command == CMD_LIMIT);

  assign timer_dec = (interval_timer != '0) ? interval_timer - HALF_W'(1) : interval_timer;
  assign steps_dec = (steps_left != '0) ? steps_left - STEPS_W'(1) : steps_left;

  // Next state for one item
  always_comb begin
    position_count_next   = position_count;
    steps_left_next       = steps_left;
    interval_timer_next   = interval_timer;
    pulse_phase_high_next = pulse_phase_high;
    moving_next           = moving;
    limit_mode_next       = limit_mode;
    going_forward_next    = going_forward;
    dir_pin_level_next    = dir_pin_level;
    done                  = 1'b0;

    if (is_move) begin
      if (!moving) begin
        going_forward_next = fwd;
        dir_pin_level_next = fwd ? cfg.forward_polarity : !cfg.forward_polarity;
        if (item.command == CMD_COUNT) begin
          limit_mode_next = 1'b0;
          if (mag_sat == '0) begin
            moving_next           = 1'b0;
            pulse_phase_high_next = 1'b0;
            interval_timer_next   = '0;
            steps_left_next       = '0;
            done                  = 1'b1;
          end else begin
            steps_left_next       = mag_sat;
            moving_next           = 1'b1;
            pulse_phase_high_next = 1'b1;
            interval_timer_next   = load_val;
          end
        end else begin
          steps_left_next = '0;
          if (item.limit_hit) begin
            moving_next           = 1'b0;
            pulse_phase_high_next = 1'b0;
            interval_timer_next   = '0;
            limit_mode_next       = 1'b0;
            done                  = 1'b1;
          end else begin
            limit_mode_next       = 1'b1;
            moving_next           = 1'b1;
            pulse_phase_high_next = 1'b1;
            interval_timer_next   = load_val;
          end
        end
      end
    end else if (moving) begin
      if (timer_dec != '0) begin
        interval_timer_next = timer_dec;
      end else if (pulse_phase_high) begin
        // high phase over, start low phase
        pulse_phase_high_next = 1'b0;
        interval_timer_next   = load_val;
      end else begin
        // low phase over: one step taken
        position_count_next = going_forward ?
                              position_count + POSITION_BITS'(1) :
                              position_count - POSITION_BITS'(1);
        if (limit_mode ? item.limit_hit : (steps_dec == '0)) begin
          moving_next           = 1'b0;
          pulse_phase_high_next = 1'b0;
          interval_timer_next   = '0;
          steps_left_next       = '0;
          limit_mode_next       = 1'b0;
          done                  = 1'b1;
        end else begin
          steps_left_next       = steps_dec;
          pulse_phase_high_next = 1'b1;
          interval_timer_next   = load_val;
        end
      end
    end
  end

  // State update
  always_ff @(posedge clk) begin
    if (rst) begin
      position_count   <= '0;
      steps_left       <= '0;
      interval_timer   <= '0;
      pulse_phase_high <= 1'b0;
      moving           <= 1'b0;
      limit_mode       <= 1'b0;
      going_forward    <= 1'b0;
      dir_pin_level    <= 1'b0;
    end else if (en) begin
      position_count   <= position_count_next;
      steps_left       <= steps_left_next;
      interval_timer   <= interval_timer_next;
      pulse_phase_high <= pulse_phase_high_next;
      moving           <= moving_next;
      limit_mode       <= limit_mode_next;
      going_forward    <= going_forward_next;
      dir_pin_level    <= dir_pin_level_next;
    end
  end

  // Result after the update
  always_comb begin
    res.step_level = pulse_phase_high_next;
    res.dir_level  = dir_pin_level_next;
    res.busy_res   = moving_next;
    res.move_done  = done;
    res.position   = POS_OUT_W'(signed'(position_count_next));
  end

endmodule

/* rtl/step_dir_pulse_generator.sv */
// Step/direction pulse generator with position counter.
// A command passes the input register, then the result register, before its result is valid.
// Throughput: one command beat per cycle; the input register and the result
// register form a two-stage pipeline that stalls only on result backpressure.
// Reset (rst, synchronous, active high): motion idle, position zero, pins low,
// half_period_ticks = 1 and forward_polarity = 1.
module step_dir_pulse_generator #(
  parameter int POSITION_BITS = sdpg_pkg::POSITION_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  sdpg_cmd_if.sink                       cmd,
  sdpg_res_if.source                     res,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [sdpg_pkg::ADDR_W-1:0]    paddr,
  input  logic [sdpg_pkg::DATA_W-1:0]    pwdata,
  output logic [sdpg_pkg::DATA_W-1:0]    prdata,
  output logic                           pready
);
  import sdpg_pkg::*;

  cfg_t    cfg;
  item_t   s1_item;
  logic    s1_valid;
  logic    s1_adv;
  logic    in_fire;
  logic    core_en;
  result_t core_res;
  result_t res_q;
  logic    res_valid;

  sdpg_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Pipeline handshake
  assign s1_adv    = !res_valid || res.ready;
  assign cmd.ready = !s1_valid || s1_adv;
  assign in_fire   = cmd.valid && cmd.ready;
  assign core_en   = s1_valid && s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item.command    <= cmd.command;
      s1_item.step_count <= cmd.step_count;
      s1_item.limit_hit  <= cmd.limit_hit;
    end
  end

  sdpg_step_core #(
    .POSITION_BITS (POSITION_BITS)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .en   (core_en),
    .item (s1_item),
    .cfg  (cfg),
    .res  (core_res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv) begin
      res_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (core_en) begin
      res_q <= core_res;
    end
  end

  assign res.valid      = res_valid;
  assign res.step_level = res_q.step_level;
  assign res.dir_level  = res_q.dir_level;
  assign res.busy_res   = res_q.busy_res;
  assign res.move_done  = res_q.move_done;
  assign res.position   = res_q.position;

endmodule

/* rtl/sdpg_checker.sv */
module sdpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        res_valid,
  input logic        res_ready,
  input logic        step_level,
  input logic        busy_res,
  input logic        move_done,
  input logic [31:0] position
);

  // A stalled result beat holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(position) && $stable(move_done))
    else $error("result beat changed while stalled");

  // Step pulse only during a move
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    res_valid && step_level |-> busy_res)
    else $error("step pulse while idle");

  // A finished move leaves the block idle with the step pin low
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && move_done |-> !busy_res && !step_level)
    else $error("move done while still busy");

  // No result beat right after reset
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result beat valid after reset");

endmodule

bind step_dir_pulse_generator sdpg_checker u_sdpg_checker (
  .clk        (clk),
  .rst        (rst),
  .res_valid  (res.valid),
  .res_ready  (res.ready),
  .step_level (res.step_level),
  .busy_res   (res.busy_res),
  .move_done  (res.move_done),
  .position   (res.position)
);
